// ===== rtl/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants for the sorted record table
// Holds the request and result item layouts, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

	localparam int DEPTH_DEFAULT = 32;
	localparam int MAX_RESULTS   = 32;
	localparam int REC_W         = 32;
	localparam int POS_W         = 5;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_SORT   = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [REC_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [REC_W-1:0] record;
		logic [POS_W-1:0]        position;
		logic [1:0]              status;
		logic                    last;
	} rsp_t;

	typedef struct packed {
		logic valid;
		rsp_t data;
	} seq_res_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_table_with_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_with_binary_search: record table with sort and search
// Sequencer and record RAM behind a registered result stage.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries one operation:
//   append a record, sort and emit the whole table, or binary search a key.
//   Result channel (res_valid / res_stall / res_data) returns the results,
//   last set on the final one of each request.
//   One request is in work at a time; req_stall stays high until its last
//   result has been handed to the output register.
//   Append: the record is written and its result issued from the dispatch
//   state. Search hit: the result follows at most log2(n)+1 probes,
//   each probe being one RAM read and compare; a miss ends with one more
//   step for the final bound check.
//   Sort of n records: exchange passes through the single RAM read port,
//   then each record is emitted with one RAM read and one output state.
//   Reset clears the record count and the control state; RAM contents are
//   left as they are and never read before written.
//   A stalled result holds in the output register; the sequencer waits for
//   the slot to free and meanwhile accepts nothing new.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_with_binary_search #(
	parameter int DEPTH = stb_pkg::DEPTH_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire stb_pkg::req_t req_data,
	output logic               res_valid,
	input  wire logic          res_stall,
	output stb_pkg::rsp_t      res_data
);

	import stb_pkg::*;

	localparam int IW = $clog2(DEPTH);

	seq_res_t         seq_res;
	logic             out_free;
	logic             res_valid_q;
	rsp_t             res_q;

	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [REC_W-1:0] ram_wdata;
	logic             ram_re;
	logic [IW-1:0]    ram_raddr;
	logic [REC_W-1:0] ram_rdata;

	// slot is free when empty or being drained this cycle
	assign out_free = !res_valid_q || !res_stall;

	stb_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.out_free  (out_free),
		.res       (seq_res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// record store
	stb_ram #(
		.WIDTH(REC_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: advance when free, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= seq_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && seq_res.valid) begin
			res_q <= seq_res.data;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

// ===== rtl/stb_ram.sv =====
// ----------------------------------------------------------------------------
// stb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stb_seq.sv =====
// ----------------------------------------------------------------------------
// stb_seq: operation sequencer for the sorted record table
// Runs append, exchange sort with emit, and binary search against the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_seq #(
	parameter int DEPTH = stb_pkg::DEPTH_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire stb_pkg::req_t            req_data,
	input  wire logic                     out_free,
	output stb_pkg::seq_res_t             res,
	output logic                          ram_we,
	output logic [$clog2(DEPTH)-1:0]      ram_waddr,
	output logic [stb_pkg::REC_W-1:0]     ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(DEPTH)-1:0]      ram_raddr,
	input  wire logic [stb_pkg::REC_W-1:0] ram_rdata
);

	import stb_pkg::*;

	localparam int IW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int IXW = IW + 1;
	localparam int SW  = IW + 2;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_DISP  = 10'b00_0000_0010,
		S_LOADI = 10'b00_0000_0100,
		S_WAITI = 10'b00_0000_1000,
		S_CMP   = 10'b00_0001_0000,
		S_WRI   = 10'b00_0010_0000,
		S_E_RD  = 10'b00_0100_0000,
		S_E_OUT = 10'b00_1000_0000,
		S_S_RD  = 10'b01_0000_0000,
		S_S_CMP = 10'b10_0000_0000
	} state_t;

	state_t                  state_q;
	logic [1:0]              op_q;
	logic signed [REC_W-1:0] val_q;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           i_q;
	logic [IW-1:0]           j_q;
	logic [IW-1:0]           k_q;
	logic signed [REC_W-1:0] cur_q;
	logic signed [SW-1:0]    lo_q;
	logic signed [SW-1:0]    hi_q;
	logic [IW-1:0]           mid_q;

	logic [IXW-1:0]          cnt_ext;
	logic [IXW-1:0]          ip2;
	logic [IXW-1:0]          jp1;
	logic [IXW-1:0]          kp1;
	logic                    full;
	logic                    swap;
	logic                    hit;
	logic                    less;
	logic                    emit_last;
	logic signed [SW-1:0]    lohi_sum;
	logic [IW-1:0]           mid_idx;
	logic                    fire;
	logic signed [REC_W-1:0] rd_s;

	assign cnt_ext   = IXW'(count_q);
	assign ip2       = IXW'(i_q) + IXW'(2);
	assign jp1       = IXW'(j_q) + IXW'(1);
	assign kp1       = IXW'(k_q) + IXW'(1);
	assign full      = (count_q == CW'(DEPTH));
	assign rd_s      = $signed(ram_rdata);
	assign swap      = (cur_q > rd_s);
	assign hit       = (rd_s == val_q);
	assign less      = (rd_s < val_q);
	assign emit_last = (kp1 == cnt_ext) || (32'(kp1) == MAX_RESULTS);
	assign lohi_sum  = lo_q + hi_q;
	assign mid_idx   = lohi_sum[IW:1];
	assign fire      = res.valid && out_free;
	assign req_stall = (state_q != S_IDLE);

	// result item for the current state
	always_comb begin
		res = '0;
		unique case (state_q)
			S_DISP: begin
				if (op_q == OP_APPEND) begin
					res.valid         = 1'b1;
					res.data.record   = val_q;
					res.data.position = full ? '0 : POS_W'(count_q);
					res.data.status   = full ? ST_FULL : ST_OK;
					res.data.last     = 1'b1;
				end else if (op_q == OP_SORT && count_q == '0) begin
					res.valid         = 1'b1;
					res.data.status   = ST_EMPTY;
					res.data.last     = 1'b1;
				end
			end
			S_E_OUT: begin
				res.valid         = 1'b1;
				res.data.record   = rd_s;
				res.data.position = POS_W'(k_q);
				res.data.status   = ST_OK;
				res.data.last     = emit_last;
			end
			S_S_RD: begin
				if (lo_q > hi_q) begin
					res.valid       = 1'b1;
					res.data.status = ST_NOT_FOUND;
					res.data.last   = 1'b1;
				end
			end
			S_S_CMP: begin
				if (hit) begin
					res.valid         = 1'b1;
					res.data.record   = val_q;
					res.data.position = POS_W'(mid_q);
					res.data.status   = ST_OK;
					res.data.last     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cur_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_DISP: begin
				if (op_q == OP_APPEND && !full && out_free) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[IW-1:0];
					ram_wdata = val_q;
				end
			end
			S_LOADI: begin
				ram_re    = 1'b1;
				ram_raddr = i_q;
			end
			S_WAITI: begin
				ram_re    = 1'b1;
				ram_raddr = IW'(IXW'(i_q) + IXW'(1));
			end
			S_CMP: begin
				ram_we    = swap;
				ram_waddr = j_q;
				if (jp1 < cnt_ext) begin
					ram_re    = 1'b1;
					ram_raddr = jp1[IW-1:0];
				end
			end
			S_WRI: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
			end
			S_E_RD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
			end
			S_S_RD: begin
				if (!(lo_q > hi_q)) begin
					ram_re    = 1'b1;
					ram_raddr = mid_idx;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (op_q)
						OP_APPEND: begin
							if (out_free) begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_IDLE;
							end
						end
						OP_SORT: begin
							if (count_q == '0) begin
								if (out_free) begin
									state_q <= S_IDLE;
								end
							end else if (cnt_ext < IXW'(2)) begin
								state_q <= S_E_RD;
							end else begin
								state_q <= S_LOADI;
							end
						end
						OP_SEARCH: state_q <= S_S_RD;
						default:   state_q <= S_IDLE;
					endcase
				end
				S_LOADI: state_q <= S_WAITI;
				S_WAITI: state_q <= S_CMP;
				S_CMP: begin
					if (!(jp1 < cnt_ext)) begin
						state_q <= S_WRI;
					end
				end
				S_WRI: begin
					// next pass while two or more records remain past this one, else emit
					state_q <= (ip2 < cnt_ext) ? S_LOADI : S_E_RD;
				end
				S_E_RD: state_q <= S_E_OUT;
				S_E_OUT: begin
					if (out_free) begin
						state_q <= emit_last ? S_IDLE : S_E_RD;
					end
				end
				S_S_RD: begin
					if (lo_q > hi_q) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_S_CMP;
					end
				end
				S_S_CMP: begin
					if (hit) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_q  <= req_data.operation;
					val_q <= req_data.value;
				end
			end
			S_DISP: begin
				i_q  <= '0;
				k_q  <= '0;
				lo_q <= '0;
				hi_q <= $signed(SW'(count_q)) - SW'(1);
			end
			S_WAITI: begin
				cur_q <= rd_s;
				j_q   <= IW'(IXW'(i_q) + IXW'(1));
			end
			S_CMP: begin
				if (swap) begin
					cur_q <= rd_s;
				end
				j_q <= jp1[IW-1:0];
			end
			S_WRI: begin
				i_q <= IW'(IXW'(i_q) + IXW'(1));
			end
			S_E_OUT: begin
				if (out_free) begin
					k_q <= kp1[IW-1:0];
				end
			end
			S_S_RD: begin
				mid_q <= mid_idx;
			end
			S_S_CMP: begin
				if (!hit) begin
					if (less) begin
						lo_q <= $signed(SW'(mid_q)) + SW'(1);
					end else begin
						hi_q <= $signed(SW'(mid_q)) - SW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record count above table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("record count moved by other than one append");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_DISP || state_q == S_CMP || state_q == S_WRI))
		else $error("table write outside append or sort");

	a_fire_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (state_q == S_DISP || state_q == S_E_OUT || state_q == S_S_RD ||
			state_q == S_S_CMP))
		else $error("result issued from a non-result state");
`endif

endmodule

`default_nettype wire
